// File: rtl/bffa_pkg.sv
// shared types, constants and helpers for the bitmap first-free allocator
package bffa_pkg;

  localparam int unsigned NUM_W    = 14;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned WORD_LSB = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [NUM_W-1:0] BITS_IN_USE_RST = 14'd8192;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BITS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREE_START  = 1'd1;

  typedef struct packed {
    logic             op;
    logic [NUM_W-1:0] entry_number;
  } req_t;

  typedef struct packed {
    logic [NUM_W-1:0]  granted_number;
    logic [CNT_W-1:0]  free_count;
    logic [STAT_W-1:0] status;
  } rsp_t;

  // free counter load request from the register file
  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] value;
  } cnt_load_t;

  // lowest set bit of a word: {found, position}
  function automatic logic [WORD_LSB:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [WORD_LSB:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        r = {1'b1, WORD_LSB'(i)};
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/bffa_bitmap_ram.sv
// single-port bitmap word memory, registered read data, read-first
module bffa_bitmap_ram #(
  parameter int unsigned WORDS = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                addr_i,
  input  logic [bffa_pkg::WORD_W-1:0]  wdata_i,
  output logic [bffa_pkg::WORD_W-1:0]  rdata_o
);
  import bffa_pkg::*;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bffa_ctrl.sv
// request sequencer: clearing pass, word scan, read-modify-write, result register
module bffa_ctrl #(
  parameter int unsigned MAP_BITS = 8192,
  parameter int unsigned WORDS    = 256,
  parameter int unsigned AW       = 8,
  parameter int unsigned LIM_W    = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [LIM_W-1:0]             lim_i,
  input  bffa_pkg::cnt_load_t          cnt_load_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bffa_pkg::req_t               in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bffa_pkg::rsp_t               out_data_o,
  output logic                         mem_we_o,
  output logic [AW-1:0]                mem_addr_o,
  output logic [bffa_pkg::WORD_W-1:0]  mem_wdata_o,
  input  logic [bffa_pkg::WORD_W-1:0]  mem_rdata_i
);
  import bffa_pkg::*;

  localparam int unsigned BIT_W = AW + WORD_LSB;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_CHK,
    S_RESP
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic              op_q, op_d;
  logic [WORD_LSB-1:0] bit_q, bit_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  rsp_t              res_q, res_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  logic [31:0]       num_ext, lim_ext, base_ext, rem;
  logic [31:0]       idx_ext;
  logic [BIT_W-1:0]  base;
  logic [WORD_W-1:0] mask;
  logic [WORD_LSB:0] hit;
  logic              last_word;

  assign num_ext  = 32'(in_data_i.entry_number);
  assign lim_ext  = 32'(lim_i);
  assign idx_ext  = num_ext - 32'd1;
  assign base     = {addr_q, {WORD_LSB{1'b0}}};
  assign base_ext = 32'(base);
  assign rem      = lim_ext - base_ext;
  assign last_word = (rem <= 32'(WORD_W));
  assign mask = (rem >= 32'(WORD_W)) ? '1 : ((WORD_W'(1) << rem[WORD_LSB-1:0]) - WORD_W'(1));
  assign hit  = lowest_set(~mem_rdata_i & mask);

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    op_d        = op_q;
    bit_d       = bit_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we_o    = 1'b0;
    mem_addr_o  = addr_q;
    mem_wdata_o = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cnt_load_i.load) begin
      cnt_d = cnt_load_i.value;
    end

    unique case (state_q)
      S_CLEAR: begin
        mem_we_o = 1'b1;
        addr_d   = addr_q + AW'(1);
        if (addr_q == AW'(WORDS - 1)) begin
          addr_d  = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = in_data_i.op;
          res_d.granted_number = '0;
          res_d.free_count     = cnt_q;
          if (in_data_i.op == OP_ALLOC) begin
            if (lim_ext == 32'd0) begin
              res_d.status = STAT_FULL;
              state_d      = S_RESP;
            end else begin
              addr_d     = '0;
              mem_addr_o = '0;
              state_d    = S_CHK;
            end
          end else begin
            if (num_ext == 32'd0 || num_ext > lim_ext) begin
              res_d.status = STAT_RANGE;
              state_d      = S_RESP;
            end else begin
              addr_d     = idx_ext[BIT_W-1:WORD_LSB];
              bit_d      = idx_ext[WORD_LSB-1:0];
              mem_addr_o = idx_ext[BIT_W-1:WORD_LSB];
              state_d    = S_CHK;
            end
          end
        end
      end
      S_CHK: begin
        if (op_q == OP_FREE) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = mem_rdata_i & ~(WORD_W'(1) << bit_q);
          cnt_d       = cnt_q + CNT_W'(1);
          res_d.granted_number = '0;
          res_d.free_count     = cnt_q + CNT_W'(1);
          res_d.status         = STAT_OK;
          state_d = S_RESP;
        end else if (hit[WORD_LSB]) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = mem_rdata_i | (WORD_W'(1) << hit[WORD_LSB-1:0]);
          cnt_d       = cnt_q - CNT_W'(1);
          res_d.granted_number =
            NUM_W'(base_ext + 32'(hit[WORD_LSB-1:0]) + 32'd1);
          res_d.free_count     = cnt_q - CNT_W'(1);
          res_d.status         = STAT_OK;
          state_d = S_RESP;
        end else if (last_word) begin
          res_d.granted_number = '0;
          res_d.free_count     = cnt_q;
          res_d.status         = STAT_FULL;
          state_d = S_RESP;
        end else begin
          addr_d     = addr_q + AW'(1);
          mem_addr_o = addr_q + AW'(1);
        end
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      addr_q      <= '0;
      op_q        <= OP_ALLOC;
      bit_q       <= '0;
      cnt_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      op_q        <= op_d;
      bit_q       <= bit_d;
      cnt_q       <= cnt_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/bitmap_first_free_allocator.sv
// top level of the bitmap first-free allocator: config registers, bitmap memory, sequencer

// first-fit allocator over a bitmap of MAP_BITS entries held in a 32-bit-wide
// single-port memory, plus a 32-bit free counter. an allocate beat scans the
// memory one word per cycle from word 0 and takes the lowest clear entry below
// the configured in-use count (capped at MAP_BITS); a free beat clears the given
// one-based entry with one read-modify-write. an allocate reads 1 to
// ceil(limit/32) words (256 at the default size). one request is in work at a
// time; the next beat is taken while the previous result still waits in the
// output register. after reset the block runs a clearing pass over every
// memory word, during which input stays stalled; config writes are taken at
// any time, but are meant to land only while the block is idle. writing
// free_count_start reloads the free counter.
module bitmap_first_free_allocator #(
  parameter int unsigned MAP_BITS = 8192
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  bffa_pkg::req_t                    in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output bffa_pkg::rsp_t                    out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bffa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bffa_pkg::CFG_DAT_W-1:0]    cfg_data_i
);
  import bffa_pkg::*;

  // memory geometry
  localparam int unsigned WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned LIM_W = $clog2(MAP_BITS + 1);

  logic [NUM_W-1:0]  bits_in_use_q, bits_in_use_d;
  logic [LIM_W-1:0]  lim;
  cnt_load_t         cnt_load;
  logic              cfg_wr;

  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  // config port never back-pressures
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // register decode
  always_comb begin
    bits_in_use_d  = bits_in_use_q;
    cnt_load.load  = 1'b0;
    cnt_load.value = cfg_data_i;
    if (cfg_wr) begin
      unique case (cfg_index_i)
        CFG_BITS_IN_USE: bits_in_use_d = cfg_data_i[NUM_W-1:0];
        CFG_FREE_START:  cnt_load.load = 1'b1;
        default:         bits_in_use_d = bits_in_use_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_in_use_q <= BITS_IN_USE_RST;
    end else begin
      bits_in_use_q <= bits_in_use_d;
    end
  end

  // in-use count saturates at the bitmap size
  assign lim = (32'(bits_in_use_q) > 32'(MAP_BITS)) ? LIM_W'(MAP_BITS)
                                                     : LIM_W'(bits_in_use_q);

  bffa_bitmap_ram #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  bffa_ctrl #(
    .MAP_BITS (MAP_BITS),
    .WORDS    (WORDS),
    .AW       (AW),
    .LIM_W    (LIM_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lim_i       (lim),
    .cnt_load_i  (cnt_load),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

`ifndef SYNTHESIS
  // one request in work at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("beat accepted while a request was in work");

  // a granted entry always comes with ok status
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.granted_number != '0 |-> out_data_o.status == STAT_OK)
    else $error("nonzero grant with non-ok status");

  // status never carries the unused code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == STAT_OK || out_data_o.status == STAT_FULL ||
                     out_data_o.status == STAT_RANGE))
    else $error("illegal status code");
`endif

endmodule
